### rtl/core/lpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpr_pkg: shared types and constants for the LWE recovery core
// Field widths, step counts, register indexes, sequencer states and the
// load/step control bundle used by the serial datapath units.
// ----------------------------------------------------------------------------
package lpr_pkg;

    // Fixed field widths
    localparam int FIELD_W = 32;
    localparam int SCALE_W = 31;
    // Rounding numerator 2*d + scale needs two bits over a word
    localparam int NUM_W   = FIELD_W + 2;
    localparam int CNT_W   = 6;

    // Last step index of each serial phase
    localparam logic [CNT_W-1:0] WORD_LAST = CNT_W'(FIELD_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(NUM_W - 1);

    typedef logic [FIELD_W-1:0] t_word;
    typedef logic [SCALE_W-1:0] t_scale;

    typedef enum logic [0:0] {
        REG_MODULUS = 1'b0,
        REG_SCALE   = 1'b1
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_MUL,
        ST_ACC,
        ST_DIFF,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_step_ctrl;

endpackage

### rtl/core/lpr_intf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpr_intf: channel interfaces of the LWE recovery core
// Input pair channel, result channel and register write channel, each a
// valid/ready handshake with a source and a sink modport.
// ----------------------------------------------------------------------------
interface lpr_item_if;
    logic           valid;
    logic           ready;
    lpr_pkg::t_word hint_value;
    lpr_pkg::t_word secret_value;
    lpr_pkg::t_word answer_value;
    logic           last;

    modport source (output valid, hint_value, secret_value, answer_value, last,
                    input ready);
    modport sink (input valid, hint_value, secret_value, answer_value, last,
                  output ready);
endinterface

interface lpr_result_if;
    logic           valid;
    logic           ready;
    lpr_pkg::t_word recovered_value;

    modport source (output valid, recovered_value, input ready);
    modport sink (input valid, recovered_value, output ready);
endinterface

interface lpr_cfg_if;
    logic              valid;
    logic              ready;
    lpr_pkg::t_reg_idx index;
    lpr_pkg::t_word    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/lpr_reduce.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpr_reduce: bit-serial modular reduction lane
// Shifts a word in MSB first and keeps the running remainder below q with
// one compare and subtract per bit. The result is ready after one word.
// ----------------------------------------------------------------------------
module lpr_reduce #(
    parameter int MB = 32
) (
    input  logic                i_clk,
    input  lpr_pkg::t_step_ctrl i_ctrl,
    input  lpr_pkg::t_word      i_value,
    input  logic [MB:0]         i_q,
    output logic [MB-1:0]       o_res
);

    lpr_pkg::t_word r_shift, n_shift;
    logic [MB-1:0]  r_rem, n_rem;
    logic [MB:0]    w_trial;
    logic [MB:0]    w_sub;

    // Double the remainder, bring in the next bit, fold back below q
    always_comb begin
        w_trial = {r_rem, r_shift[lpr_pkg::FIELD_W-1]};
        w_sub   = w_trial - i_q;
        n_shift = r_shift;
        n_rem   = r_rem;
        if (i_ctrl.load) begin
            n_shift = i_value;
            n_rem   = '0;
        end else if (i_ctrl.step) begin
            n_shift = {r_shift[lpr_pkg::FIELD_W-2:0], 1'b0};
            n_rem   = (w_trial >= i_q) ? w_sub[MB-1:0] : w_trial[MB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
        r_rem   <= n_rem;
    end

    assign o_res = r_rem;

endmodule

### rtl/core/lpr_mulmod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpr_mulmod: interleaved bit-serial modular multiplier
// Walks the multiplier word MSB first: double the partial product mod q,
// then add the reduced multiplicand mod q where the bit is set.
// ----------------------------------------------------------------------------
module lpr_mulmod #(
    parameter int MB = 32
) (
    input  logic                i_clk,
    input  lpr_pkg::t_step_ctrl i_ctrl,
    input  lpr_pkg::t_word      i_bits,
    input  logic [MB-1:0]       i_h,
    input  logic [MB:0]         i_q,
    output logic [MB-1:0]       o_prod
);

    lpr_pkg::t_word r_bits, n_bits;
    logic [MB-1:0]  r_p, n_p;
    logic [MB:0]    w_dbl, w_dbl_sub;
    logic [MB-1:0]  w_dbl_red;
    logic [MB:0]    w_add, w_add_sub;
    logic [MB-1:0]  w_add_red;

    // Double, reduce, then conditionally add the multiplicand and reduce
    always_comb begin
        w_dbl     = {r_p, 1'b0};
        w_dbl_sub = w_dbl - i_q;
        w_dbl_red = (w_dbl >= i_q) ? w_dbl_sub[MB-1:0] : w_dbl[MB-1:0];
        w_add     = {1'b0, w_dbl_red} + {1'b0, i_h};
        w_add_sub = w_add - i_q;
        w_add_red = (w_add >= i_q) ? w_add_sub[MB-1:0] : w_add[MB-1:0];
        n_bits    = r_bits;
        n_p       = r_p;
        if (i_ctrl.load) begin
            n_bits = i_bits;
            n_p    = '0;
        end else if (i_ctrl.step) begin
            n_bits = {r_bits[lpr_pkg::FIELD_W-2:0], 1'b0};
            n_p    = r_bits[lpr_pkg::FIELD_W-1] ? w_add_red : w_dbl_red;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bits <= n_bits;
        r_p    <= n_p;
    end

    assign o_prod = r_p;

endmodule

### rtl/core/lpr_round_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpr_round_div: bit-serial restoring divider for the final rounding
// Divides the rounding numerator by twice the scale, one quotient bit per
// cycle; quotient bits shift in behind the numerator bits.
// ----------------------------------------------------------------------------
module lpr_round_div (
    input  logic                       i_clk,
    input  lpr_pkg::t_step_ctrl        i_ctrl,
    input  logic [lpr_pkg::NUM_W-1:0]  i_num,
    input  lpr_pkg::t_word             i_den,
    output lpr_pkg::t_word             o_quot
);

    logic [lpr_pkg::NUM_W-1:0]   r_num, n_num;
    lpr_pkg::t_word              r_rem, n_rem;
    lpr_pkg::t_word              r_den, n_den;
    logic [lpr_pkg::FIELD_W:0]   w_trial, w_sub;
    logic                        w_ge;

    // Shift in the next numerator bit and subtract the divisor if it fits
    always_comb begin
        w_trial = {r_rem, r_num[lpr_pkg::NUM_W-1]};
        w_ge    = (w_trial >= {1'b0, r_den});
        w_sub   = w_trial - {1'b0, r_den};
        n_num   = r_num;
        n_rem   = r_rem;
        n_den   = r_den;
        if (i_ctrl.load) begin
            n_num = i_num;
            n_rem = '0;
            n_den = i_den;
        end else if (i_ctrl.step) begin
            n_num = {r_num[lpr_pkg::NUM_W-2:0], w_ge};
            n_rem = w_ge ? w_sub[lpr_pkg::FIELD_W-1:0] : w_trial[lpr_pkg::FIELD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_num <= n_num;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_quot = r_num[lpr_pkg::FIELD_W-1:0];

endmodule

### rtl/core/lwe_pir_recover_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwe_pir_recover_core: LWE decryption with rounding, bit-serial datapath
// Accumulates a modular dot product of hint and secret pairs and, on the
// last pair of a row, rounds (answer - dot) mod q over the scale.
// ----------------------------------------------------------------------------
//
//  channel    dir  carries                                          request
//  i_item     in   hint_value, secret_value, answer_value, last     one pair
//  o_result   out  recovered_value                                  one value
//  i_cfg      in   index (modulus, scale), data                     one write
//
//  A pair that is not last runs serial reduction (hint, answer, accumulator in
//  parallel), interleaved modular multiply and an accumulate step, then
//  returns to idle for the next accept. A last pair adds a difference step,
//  a restoring divide and a handoff step; each unit retires one bit per cycle.
//  Synchronous active-low reset clears the sequencer, accumulator, result
//  valid and the registers (modulus all ones, scale one).
//  A result waiting in the output register does not block input; only a
//  new result finishing while the old one is still untaken holds the core.
// ----------------------------------------------------------------------------
module lwe_pir_recover_core #(
    parameter int MODULUS_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    lpr_item_if.sink             i_item,
    lpr_result_if.source         o_result,
    lpr_cfg_if.sink              i_cfg
);

    localparam int MB = MODULUS_BITS;

    lpr_pkg::t_state     r_state, n_state;
    logic [lpr_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic [MB:0]         r_q;
    lpr_pkg::t_scale     r_scale;
    logic [MB-1:0]       r_acc;
    logic [MB-1:0]       r_dot;
    logic                r_last;
    logic                r_res_valid;
    lpr_pkg::t_word      r_res;

    lpr_pkg::t_step_ctrl w_red_ctrl, w_mul_ctrl, w_div_ctrl;
    logic                w_item_ready;
    logic                w_res_load;
    logic [MB-1:0]       w_hint_red, w_ans_red, w_acc_red, w_prod;
    logic [MB:0]         w_acc_sum, w_acc_sub;
    logic [MB-1:0]       w_acc_new;
    logic [MB:0]         w_diff, w_wrap;
    logic [MB-1:0]       w_d;
    logic [lpr_pkg::NUM_W-1:0] w_num;
    lpr_pkg::t_word      w_den;
    lpr_pkg::t_word      w_quot;
    logic [MB-1:0]       w_mod_low;
    lpr_pkg::t_scale     w_scale_low;

    // Serial units
    lpr_reduce #(.MB(MB)) u_red_hint (
        .i_clk   (i_clk),
        .i_ctrl  (w_red_ctrl),
        .i_value (i_item.hint_value),
        .i_q     (r_q),
        .o_res   (w_hint_red)
    );

    lpr_reduce #(.MB(MB)) u_red_ans (
        .i_clk   (i_clk),
        .i_ctrl  (w_red_ctrl),
        .i_value (i_item.answer_value),
        .i_q     (r_q),
        .o_res   (w_ans_red)
    );

    lpr_reduce #(.MB(MB)) u_red_acc (
        .i_clk   (i_clk),
        .i_ctrl  (w_red_ctrl),
        .i_value (lpr_pkg::FIELD_W'(r_acc)),
        .i_q     (r_q),
        .o_res   (w_acc_red)
    );

    lpr_mulmod #(.MB(MB)) u_mulmod (
        .i_clk   (i_clk),
        .i_ctrl  (w_mul_ctrl),
        .i_bits  (i_item.secret_value),
        .i_h     (w_hint_red),
        .i_q     (r_q),
        .o_prod  (w_prod)
    );

    lpr_round_div u_round_div (
        .i_clk   (i_clk),
        .i_ctrl  (w_div_ctrl),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_quot  (w_quot)
    );

    // Accumulate the product, then form the difference and rounding operands
    always_comb begin
        w_acc_sum = {1'b0, w_acc_red} + {1'b0, w_prod};
        w_acc_sub = w_acc_sum - r_q;
        w_acc_new = (w_acc_sum >= r_q) ? w_acc_sub[MB-1:0] : w_acc_sum[MB-1:0];
        w_diff    = {1'b0, w_ans_red} - {1'b0, r_dot};
        w_wrap    = w_diff + r_q;
        w_d       = (w_ans_red >= r_dot) ? w_diff[MB-1:0] : w_wrap[MB-1:0];
        w_num     = lpr_pkg::NUM_W'({w_d, 1'b0}) + lpr_pkg::NUM_W'(r_scale);
        w_den     = {r_scale, 1'b0};
    end

    // Decode register writes: a zero modulus means 2^MB, a zero scale means one
    assign w_mod_low   = i_cfg.data[MB-1:0];
    assign w_scale_low = i_cfg.data[lpr_pkg::SCALE_W-1:0];
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q     <= {1'b0, {MB{1'b1}}};
            r_scale <= lpr_pkg::t_scale'(1);
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                lpr_pkg::REG_MODULUS: begin
                    r_q <= (w_mod_low == '0) ? {1'b1, {MB{1'b0}}} : {1'b0, w_mod_low};
                end
                lpr_pkg::REG_SCALE: begin
                    r_scale <= (w_scale_low == '0) ? lpr_pkg::t_scale'(1) : w_scale_low;
                end
                default: begin
                end
            endcase
        end
    end

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lpr_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Next state and unit controls
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        w_red_ctrl   = '0;
        w_mul_ctrl   = '0;
        w_div_ctrl   = '0;
        w_item_ready = 1'b0;
        w_res_load   = 1'b0;
        unique case (r_state)
            lpr_pkg::ST_IDLE: begin
                w_item_ready = 1'b1;
                if (i_item.valid) begin
                    w_red_ctrl.load = 1'b1;
                    w_mul_ctrl.load = 1'b1;
                    n_cnt           = '0;
                    n_state         = lpr_pkg::ST_REDUCE;
                end
            end
            lpr_pkg::ST_REDUCE: begin
                w_red_ctrl.step = 1'b1;
                n_cnt           = r_cnt + 1'b1;
                if (r_cnt == lpr_pkg::WORD_LAST) begin
                    n_cnt   = '0;
                    n_state = lpr_pkg::ST_MUL;
                end
            end
            lpr_pkg::ST_MUL: begin
                w_mul_ctrl.step = 1'b1;
                n_cnt           = r_cnt + 1'b1;
                if (r_cnt == lpr_pkg::WORD_LAST) begin
                    n_cnt   = '0;
                    n_state = lpr_pkg::ST_ACC;
                end
            end
            lpr_pkg::ST_ACC: begin
                n_state = r_last ? lpr_pkg::ST_DIFF : lpr_pkg::ST_IDLE;
            end
            lpr_pkg::ST_DIFF: begin
                w_div_ctrl.load = 1'b1;
                n_cnt           = '0;
                n_state         = lpr_pkg::ST_DIV;
            end
            lpr_pkg::ST_DIV: begin
                w_div_ctrl.step = 1'b1;
                n_cnt           = r_cnt + 1'b1;
                if (r_cnt == lpr_pkg::DIV_LAST) begin
                    n_cnt   = '0;
                    n_state = lpr_pkg::ST_DONE;
                end
            end
            lpr_pkg::ST_DONE: begin
                // Hold until the output register is free
                if (!r_res_valid || o_result.ready) begin
                    w_res_load = 1'b1;
                    n_state    = lpr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lpr_pkg::ST_IDLE;
            end
        endcase
    end

    assign i_item.ready = w_item_ready;

    // Accumulator: update after each pair, clear after the last of a row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (r_state == lpr_pkg::ST_ACC) begin
            r_acc <= r_last ? '0 : w_acc_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && w_item_ready) begin
            r_last <= i_item.last;
        end
        if (r_state == lpr_pkg::ST_ACC) begin
            r_dot <= w_acc_new;
        end
        if (w_res_load) begin
            r_res <= w_quot;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (w_res_load) begin
            r_res_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_res_valid <= 1'b0;
        end
    end

    assign o_result.valid           = r_res_valid;
    assign o_result.recovered_value = r_res;

`ifndef SYNTHESIS
    // Accumulator stays below the modulus it was reduced against
    a_acc_below_q: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lpr_pkg::ST_ACC) |=> ({1'b0, r_acc} < $past(r_q)))
        else $error("accumulator not reduced below q");

    // A row end leaves the accumulator cleared
    a_acc_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lpr_pkg::ST_DIFF) |-> (r_acc == '0))
        else $error("accumulator not cleared after last pair");

    // A new result appears only from the handoff state
    a_res_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_res_valid) |-> ($past(r_state) == lpr_pkg::ST_DONE))
        else $error("result raised outside handoff");

    // Divider never runs past its last step
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lpr_pkg::ST_DIV) |-> (r_cnt <= lpr_pkg::DIV_LAST))
        else $error("divider step count overrun");

    // Handoff never overwrites a result that was not taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_load && r_res_valid) |-> o_result.ready)
        else $error("pending result overwritten");
`endif

endmodule
